/* src/mts_pkg.sv */
// Shared types and constants for the min tracking stack.
// No dependencies; imported by every module of the block.
`default_nettype none

package mts_pkg;

    localparam int VALUE_W = 32;
    localparam int CAP_W   = 11;
    localparam int COUNT_W = 11;
    localparam int STAT_W  = 2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic
    {
        FSM_IDLE,
        FSM_RESP
    } fsm_state_t;

endpackage

`default_nettype wire

/* src/mts_ram.sv */
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// Uses mts_pkg for the data width.
`default_nettype none

module mts_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [mts_pkg::VALUE_W-1:0]   wr_data,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output      logic [mts_pkg::VALUE_W-1:0]   rd_data
);
    import mts_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/min_tracking_stack_unit.sv */
// Top level of the min tracking stack: command handshake, counts, cached tops.
// Depends on mts_pkg and mts_ram (element store and minimum store).
//
//  channel   ports                                        handshake
//  -------   -------------------------------------------  ------------------------
//  command   command, value                                start && !busy
//  result    status, top_value, min_value, is_empty,      done (one cycle, no stall)
//            count
//  config    cfg_data                                     cfg_write
//
// Every command is accepted on one edge and its result is strobed on done in
// the next cycle, while busy is high. Busy drops at the edge that retires the
// result, so a new command cannot be accepted while the last one is still
// pending. The response state is needed because the stores have a registered
// read: a pop must fetch the new top element and possibly the new top minimum.
// Pushes write the stores at the accept edge. Reset clears the counts and sets
// capacity to 1024; the stores need no clearing since only entries below the
// counts are read. The receiver cannot stall, so a result is never held.
`default_nettype none

module min_tracking_stack_unit #(
    parameter int DEPTH = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output      logic                                busy,
    input  wire logic                                command,
    input  wire logic signed [mts_pkg::VALUE_W-1:0]  value,
    output      logic                                done,
    output      logic [mts_pkg::STAT_W-1:0]          status,
    output      logic signed [mts_pkg::VALUE_W-1:0]  top_value,
    output      logic signed [mts_pkg::VALUE_W-1:0]  min_value,
    output      logic                                is_empty,
    output      logic [mts_pkg::COUNT_W-1:0]         count,
    input  wire logic                                cfg_write,
    input  wire logic [mts_pkg::CAP_W-1:0]           cfg_data
);
    import mts_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > CAP_W) ? CW : CAP_W;

    fsm_state_t state_reg, state_next;

    logic [CAP_W-1:0]          capacity_reg;
    logic [CW-1:0]             ecount_reg, ecount_next;
    logic [CW-1:0]             mcount_reg, mcount_next;
    logic [STAT_W-1:0]         status_reg, status_next;
    logic                      load_e_reg, load_e_next;
    logic                      load_m_reg, load_m_next;
    logic signed [VALUE_W-1:0] top_elem_reg, top_elem_next;
    logic signed [VALUE_W-1:0] top_min_reg, top_min_next;

    logic                      accept;
    logic                      full;
    logic                      push_ok;
    logic                      min_push;
    logic                      pop_ok;
    logic                      pop_min;
    logic [CW-1:0]             e_sub;
    logic [CW-1:0]             m_sub;
    logic [VALUE_W-1:0]        e_rdata;
    logic [VALUE_W-1:0]        m_rdata;
    logic signed [VALUE_W-1:0] cur_top;
    logic signed [VALUE_W-1:0] cur_min;

    // Decode the command at the accept edge.
    always_comb
    begin
        accept   = start && (state_reg == FSM_IDLE);
        full     = (XW'(ecount_reg) >= XW'(capacity_reg)) || (XW'(ecount_reg) >= XW'(DEPTH));
        push_ok  = accept && (command == CMD_PUSH) && !full;
        min_push = push_ok && ((mcount_reg == '0) || (value <= top_min_reg));
        pop_ok   = accept && (command == CMD_POP) && (ecount_reg != '0);
        // Drop the minimum top when the popped element equals it.
        pop_min  = pop_ok && (mcount_reg != '0) && (top_elem_reg == top_min_reg);
        e_sub    = ecount_reg - CW'(2);
        m_sub    = mcount_reg - CW'(2);
    end

    mts_ram #(.DEPTH(DEPTH), .AW(AW)) u_elem_ram (
        .clk     (clk),
        .wr_en   (push_ok),
        .wr_addr (ecount_reg[AW-1:0]),
        .wr_data (value),
        .rd_en   (pop_ok),
        .rd_addr (e_sub[AW-1:0]),
        .rd_data (e_rdata)
    );

    mts_ram #(.DEPTH(DEPTH), .AW(AW)) u_min_ram (
        .clk     (clk),
        .wr_en   (min_push),
        .wr_addr (mcount_reg[AW-1:0]),
        .wr_data (value),
        .rd_en   (pop_min),
        .rd_addr (m_sub[AW-1:0]),
        .rd_data (m_rdata)
    );

    // The fetched entries replace the cached tops in the response cycle.
    always_comb
    begin
        cur_top = load_e_reg ? $signed(e_rdata) : top_elem_reg;
        cur_min = load_m_reg ? $signed(m_rdata) : top_min_reg;
    end

    // Next state, counts and result decode.
    always_comb
    begin
        state_next    = state_reg;
        ecount_next   = ecount_reg;
        mcount_next   = mcount_reg;
        status_next   = status_reg;
        load_e_next   = load_e_reg;
        load_m_next   = load_m_reg;
        top_elem_next = top_elem_reg;
        top_min_next  = top_min_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next  = FSM_RESP;
                    load_e_next = pop_ok;
                    load_m_next = pop_min;
                    if (command == CMD_PUSH)
                    begin
                        status_next = full ? ST_OVERFLOW : ST_OK;
                    end
                    else
                    begin
                        status_next = pop_ok ? ST_OK : ST_UNDERFLOW;
                    end
                    if (push_ok)
                    begin
                        ecount_next   = ecount_reg + CW'(1);
                        top_elem_next = value;
                    end
                    if (min_push)
                    begin
                        mcount_next  = mcount_reg + CW'(1);
                        top_min_next = value;
                    end
                    if (pop_ok)
                    begin
                        ecount_next = ecount_reg - CW'(1);
                    end
                    if (pop_min)
                    begin
                        mcount_next = mcount_reg - CW'(1);
                    end
                end
            end
            FSM_RESP:
            begin
                state_next    = FSM_IDLE;
                load_e_next   = 1'b0;
                load_m_next   = 1'b0;
                top_elem_next = cur_top;
                top_min_next  = cur_min;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FSM_IDLE;
            capacity_reg <= CAP_RESET;
            ecount_reg   <= '0;
            mcount_reg   <= '0;
            status_reg   <= ST_OK;
            load_e_reg   <= 1'b0;
            load_m_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ecount_reg <= ecount_next;
            mcount_reg <= mcount_next;
            status_reg <= status_next;
            load_e_reg <= load_e_next;
            load_m_reg <= load_m_next;
            if (cfg_write)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    // Hold the cached tops; no reset, they are gated by the counts.
    always_ff @(posedge clk)
    begin
        top_elem_reg <= top_elem_next;
        top_min_reg  <= top_min_next;
    end

    // Drive the result for the single response cycle.
    always_comb
    begin
        busy      = (state_reg != FSM_IDLE);
        done      = (state_reg == FSM_RESP);
        status    = status_reg;
        is_empty  = (ecount_reg == '0);
        count     = COUNT_W'(ecount_reg);
        top_value = (ecount_reg != '0) ? cur_top : '0;
        min_value = ((ecount_reg != '0) && (mcount_reg != '0)) ? cur_min : '0;
    end

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("result strobe missing after accepted item");

    a_min_le_elem: assert property (@(posedge clk) disable iff (!rst_n)
        mcount_reg <= ecount_reg)
        else $error("minimum count exceeds element count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(ecount_reg) <= XW'(DEPTH))
        else $error("element count beyond depth");

    a_stat_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (ecount_reg == $past(ecount_reg)))
        else $error("failed command changed the count");
`endif

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for min_tracking_stack_unit: directed table, then random phases.
// Depends on mts_pkg and the RTL of the block; holds its own stack and minimum predictor.
// Checks every result strobe field by field against the oldest predicted item.
module tb_top;

    import mts_pkg::*;

    localparam int STACK_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 50;

    // One result as the block reports it
    typedef struct packed
    {
        logic [STAT_W-1:0]  status;
        logic [VALUE_W-1:0] top;
        logic [VALUE_W-1:0] minv;
        logic               empty;
        logic [COUNT_W-1:0] cnt;
    } stack_view_t;

    typedef enum logic
    {
        ROW_ITEM,
        ROW_CAP_WRITE
    } row_kind_t;

    // One row of the directed table; for a capacity write, val carries the capacity
    typedef struct
    {
        row_kind_t          kind;
        logic               cmd;
        logic [VALUE_W-1:0] val;
        bit                 typed;
        stack_view_t        view;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic                       command;
    logic signed [VALUE_W-1:0]  value;
    logic                       done;
    logic [STAT_W-1:0]          status;
    logic signed [VALUE_W-1:0]  top_value;
    logic signed [VALUE_W-1:0]  min_value;
    logic                       is_empty;
    logic [COUNT_W-1:0]         count;
    logic                       cfg_write;
    logic [CAP_W-1:0]           cfg_data;

    // Predictor state: element stack, minimum stack, counts and capacity
    logic [VALUE_W-1:0] elem_mem [STACK_DEPTH];
    logic [VALUE_W-1:0] min_mem [STACK_DEPTH];
    int unsigned        elem_cnt;
    int unsigned        min_cnt;
    int unsigned        cap_limit;

    stack_view_t        expected_views[$];
    stim_row_t          dir_rows[$];
    int                 mismatches;
    int                 cycle_cnt;

    min_tracking_stack_unit #(
        .DEPTH(STACK_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .value     (value),
        .done      (done),
        .status    (status),
        .top_value (top_value),
        .min_value (min_value),
        .is_empty  (is_empty),
        .count     (count),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Apply one command to the predicted stacks and return the result it gives
    function automatic stack_view_t apply_stack_cmd(input logic cmd, input logic [VALUE_W-1:0] val);
        stack_view_t r;
        int unsigned lim;
        lim = (cap_limit < STACK_DEPTH) ? cap_limit : STACK_DEPTH;
        r.status = ST_OK;
        if (cmd == CMD_PUSH)
        begin
            if (elem_cnt >= lim)
            begin
                r.status = ST_OVERFLOW;
            end
            else
            begin
                elem_mem[elem_cnt] = val;
                elem_cnt++;
                // Ties go onto the minimum stack too, so duplicates survive a pop
                if (min_cnt == 0 || $signed(val) <= $signed(min_mem[min_cnt-1]))
                begin
                    if (min_cnt < STACK_DEPTH)
                    begin
                        min_mem[min_cnt] = val;
                        min_cnt++;
                    end
                end
            end
        end
        else
        begin
            if (elem_cnt == 0)
            begin
                r.status = ST_UNDERFLOW;
            end
            else
            begin
                if (min_cnt != 0 && elem_mem[elem_cnt-1] == min_mem[min_cnt-1])
                    min_cnt--;
                elem_cnt--;
            end
        end
        r.top   = (elem_cnt != 0) ? elem_mem[elem_cnt-1] : '0;
        r.minv  = (elem_cnt != 0 && min_cnt != 0) ? min_mem[min_cnt-1] : '0;
        r.empty = (elem_cnt == 0);
        r.cnt   = COUNT_W'(elem_cnt);
        return r;
    endfunction

    // Hold the item on the command ports until start && !busy at an edge, then
    // record what it must produce. Leave start high for the caller.
    task automatic send_item(input logic cmd, input logic [VALUE_W-1:0] val,
                             input bit typed, input stack_view_t typed_view);
        stack_view_t pred;
        start   <= 1'b1;
        command <= cmd;
        value   <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pred = apply_stack_cmd(cmd, val);
        if (typed)
            pred = typed_view;
        expected_views.push_back(pred);
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop start and hold off until every predicted item has been reported,
    // then let the block settle.
    task automatic wait_drained();
        start <= 1'b0;
        while (expected_views.size() != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        cap_limit = cap;
        cfg_write <= 1'b0;
    endtask

    // Directed table builders
    task automatic row(input logic cmd, input logic [VALUE_W-1:0] val);
        stim_row_t r;
        r.kind  = ROW_ITEM;
        r.cmd   = cmd;
        r.val   = val;
        r.typed = 1'b0;
        r.view  = '0;
        dir_rows.push_back(r);
    endtask

    task automatic row_exp(input logic cmd, input logic [VALUE_W-1:0] val,
                           input logic [STAT_W-1:0] st, input logic [VALUE_W-1:0] top,
                           input logic [VALUE_W-1:0] minv, input logic emp,
                           input logic [COUNT_W-1:0] cnt);
        stim_row_t r;
        r.kind  = ROW_ITEM;
        r.cmd   = cmd;
        r.val   = val;
        r.typed = 1'b1;
        r.view  = '{status: st, top: top, minv: minv, empty: emp, cnt: cnt};
        dir_rows.push_back(r);
    endtask

    task automatic row_cap(input logic [CAP_W-1:0] cap);
        stim_row_t r;
        r.kind  = ROW_CAP_WRITE;
        r.cmd   = CMD_PUSH;
        r.val   = VALUE_W'(cap);
        r.typed = 1'b0;
        r.view  = '0;
        dir_rows.push_back(r);
    endtask

    // Mostly small values around zero so ties and repeated minimums happen,
    // some extremes, and full-range words so every bit toggles.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                v = $urandom_range(0, 8);
                v = v - 4;
            end
            4:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = '0;
                endcase
            end
            default:
                v = $urandom;
        endcase
        return v;
    endfunction

    task automatic run_random(input int n_items, input int push_pct, input bit allow_idle);
        logic cmd;
        for (int i = 0; i < n_items; i++)
        begin
            cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
            send_item(cmd, pick_value(), 1'b0, '0);
            // Idle in short bursts so gaps land on both the accept and result cycles
            if (allow_idle && $urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 3));
        end
    endtask

    // Result checking: every done strobe retires the oldest predicted item
    task automatic flag_field(input string fname, input logic [VALUE_W-1:0] exp_v,
                              input logic [VALUE_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        stack_view_t want;
        if (rst_n && done)
        begin
            if (expected_views.size() == 0)
            begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, {status, top_value, min_value, is_empty, count});
            end
            else
            begin
                want = expected_views.pop_front();
                flag_field("status",    VALUE_W'(want.status), VALUE_W'(status));
                flag_field("top_value", want.top,              top_value);
                flag_field("min_value", want.minv,             min_value);
                flag_field("is_empty",  VALUE_W'(want.empty),  VALUE_W'(is_empty));
                flag_field("count",     VALUE_W'(want.cnt),    VALUE_W'(count));
            end
        end
    end

    // Watchdog: end the run if the block stops answering
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        stim_row_t r;
        mismatches = 0;
        cycle_cnt  = 0;
        elem_cnt   = 0;
        min_cnt    = 0;
        cap_limit  = CAP_RESET;
        rst_n      = 1'b0;
        start      = 1'b0;
        command    = CMD_PUSH;
        value      = '0;
        cfg_write  = 1'b0;
        cfg_data   = '0;

        // Directed table. Typed rows are read straight off the spec; others go
        // through the predictor.
        row_exp(CMD_POP,  32'h0,         ST_UNDERFLOW, 32'h0,         32'h0,         1'b1, 11'd0);
        row_exp(CMD_PUSH, 32'h7FFF_FFFF, ST_OK,        32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 11'd1);
        row_exp(CMD_PUSH, 32'h8000_0000, ST_OK,        32'h8000_0000, 32'h8000_0000, 1'b0, 11'd2);
        row_exp(CMD_PUSH, 32'h8000_0000, ST_OK,        32'h8000_0000, 32'h8000_0000, 1'b0, 11'd3);
        // Equal minimum was stacked twice, so one pop keeps it
        row_exp(CMD_POP,  32'hFFFF_FFFF, ST_OK,        32'h8000_0000, 32'h8000_0000, 1'b0, 11'd2);
        row(CMD_PUSH, 32'h0);
        row(CMD_PUSH, 32'hFFFF_FFFF);
        row(CMD_POP,  32'h5A5A_5A5A);
        row(CMD_POP,  32'h0);
        row_exp(CMD_POP,  32'h0,         ST_OK,        32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 11'd1);
        // Empty again: top and minimum read as zero
        row_exp(CMD_POP,  32'h0,         ST_OK,        32'h0,         32'h0,         1'b1, 11'd0);
        // Capacity zero: every push overflows
        row_cap(11'd0);
        row_exp(CMD_PUSH, 32'h1234_5678, ST_OVERFLOW,  32'h0,         32'h0,         1'b1, 11'd0);
        row_exp(CMD_POP,  32'h0,         ST_UNDERFLOW, 32'h0,         32'h0,         1'b1, 11'd0);
        // Push on a full stack
        row_cap(11'd2);
        row(CMD_PUSH, 32'h3);
        row(CMD_PUSH, 32'h3);
        row_exp(CMD_PUSH, 32'h1,         ST_OVERFLOW,  32'h3,         32'h3,         1'b0, 11'd2);
        // Capacity lowered below the count: elements stay, pushes overflow
        row_cap(11'd1);
        row_exp(CMD_PUSH, 32'h9,         ST_OVERFLOW,  32'h3,         32'h3,         1'b0, 11'd2);
        row_exp(CMD_POP,  32'h0,         ST_OK,        32'h3,         32'h3,         1'b0, 11'd1);
        row_exp(CMD_PUSH, 32'h9,         ST_OVERFLOW,  32'h3,         32'h3,         1'b0, 11'd1);
        row_exp(CMD_POP,  32'h0,         ST_OK,        32'h0,         32'h0,         1'b1, 11'd0);
        row(CMD_PUSH, 32'hFFFF_FFFB);
        // Capacity above the store depth saturates at the depth
        row_cap(11'd2047);
        row(CMD_PUSH, 32'hA);
        row(CMD_POP,  32'h0);
        row(CMD_POP,  32'h0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            if (r.kind == ROW_CAP_WRITE)
                set_capacity(r.val[CAP_W-1:0]);
            else
                send_item(r.cmd, r.val, r.typed, r.view);
        end

        // Random phases, small capacities first so full and empty are both hit often
        set_capacity(11'd1);
        run_random(60, 50, 1'b1);
        set_capacity(11'd3);
        run_random(80, 55, 1'b1);
        set_capacity(CAP_W'($urandom_range(4, 40)));
        run_random(100, 55, 1'b1);
        // Zero capacity with elements possibly still stored
        set_capacity(11'd0);
        run_random(20, 50, 1'b1);
        // Build up a deep stack, then cut the capacity under the count
        set_capacity(11'd40);
        run_random(60, 85, 1'b1);
        set_capacity(11'd6);
        run_random(100, 40, 1'b1);
        // Grow a deep stack with the widest capacity, then unwind
        set_capacity(11'd2047);
        run_random(380, 90, 1'b1);
        run_random(60, 30, 1'b1);
        // Last stretch at the reset capacity, back to back with no idling
        set_capacity(CAP_RESET);
        run_random(80, 50, 1'b0);

        wait_drained();
        repeat (4) @(posedge clk);

        if (mismatches == 0 && expected_views.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
src/mts_pkg.sv
src/mts_ram.sv
src/min_tracking_stack_unit.sv
test/tb_top.sv
